/* rtl/mcbp_pkg.sv */
// Package for the map cell block parser: types, layout tables and skip functions.
`timescale 1ns / 1ps
package mcbp_pkg;

  localparam int unsigned CellIndexBits = 24;
  localparam int unsigned SkipBits      = 6;

  localparam logic [7:0] VerRecord12 = 8'd1;
  localparam logic [7:0] VerTab3     = 8'd3;
  localparam logic [7:0] VerTab5     = 8'd5;
  localparam logic [7:0] VerTab6     = 8'd6;
  localparam logic [7:0] VerExtra7   = 8'd7;
  localparam logic [7:0] VerWord9    = 8'd9;
  localparam logic [7:0] VerWord10   = 8'd10;
  localparam logic [7:0] VerWord11   = 8'd11;
  localparam logic [7:0] VerWord12   = 8'd12;

  localparam logic CfgIdxVersion = 1'b0;
  localparam logic CfgIdxCount   = 1'b1;

  localparam logic [3:0]  RecordLen      = 4'd12;
  localparam logic [3:0]  GatherStart    = 4'd8;
  localparam logic [31:0] BlockThreshold = 32'd1000;

  typedef enum logic [4:0] {
    PhFlag   = 5'b00001,
    PhExtra  = 5'b00010,
    PhWordLo = 5'b00100,
    PhWordHi = 5'b01000,
    PhSkip   = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [CellIndexBits-1:0] cell_index;
    logic                     blocked;
    logic                     cell_valid;
    logic                     final_res;
    logic                     bad_version;
  } res_t;

  // Skip counts per flag code, already reduced by the flag byte itself
  localparam logic [SkipBits-1:0] TabV3 [32] = '{
    6'd0, 6'd0, 6'd2, 6'd2, 6'd2, 6'd2, 6'd4, 6'd4, 6'd4, 6'd4, 6'd6, 6'd6, 6'd6, 6'd6,
    6'd8, 6'd8, 6'd1, 6'd1, 6'd3, 6'd3, 6'd3, 6'd3, 6'd5, 6'd5, 6'd5, 6'd5, 6'd7, 6'd7,
    6'd7, 6'd7, 6'd9, 6'd9};
  localparam logic [SkipBits-1:0] TabV5 [32] = '{
    6'd0, 6'd0, 6'd2, 6'd2, 6'd2, 6'd2, 6'd4, 6'd4, 6'd6, 6'd6, 6'd8, 6'd8, 6'd8, 6'd8,
    6'd10, 6'd10, 6'd1, 6'd1, 6'd3, 6'd3, 6'd3, 6'd3, 6'd5, 6'd5, 6'd7, 6'd7, 6'd9, 6'd9,
    6'd9, 6'd9, 6'd11, 6'd11};
  localparam logic [SkipBits-1:0] TabV6 [32] = '{
    6'd2, 6'd2, 6'd4, 6'd4, 6'd4, 6'd4, 6'd6, 6'd6, 6'd8, 6'd8, 6'd10, 6'd10, 6'd10, 6'd10,
    6'd12, 6'd12, 6'd3, 6'd3, 6'd5, 6'd5, 6'd5, 6'd5, 6'd7, 6'd7, 6'd9, 6'd9, 6'd11, 6'd11,
    6'd11, 6'd11, 6'd13, 6'd13};
  // Reduced by the flag byte and the extra byte
  localparam logic [SkipBits-1:0] TabV7 [32] = '{
    6'd1, 6'd1, 6'd5, 6'd5, 6'd5, 6'd5, 6'd9, 6'd9, 6'd7, 6'd7, 6'd11, 6'd11, 6'd11, 6'd11,
    6'd15, 6'd15, 6'd2, 6'd2, 6'd6, 6'd6, 6'd6, 6'd6, 6'd10, 6'd10, 6'd8, 6'd8, 6'd12, 6'd12,
    6'd12, 6'd12, 6'd16, 6'd16};

  function automatic logic [SkipBits-1:0] flag_bit_skip(input logic [7:0] f);
    logic [SkipBits-1:0] s;
    s = '0;
    if (f[1]) s = s + 6'd4;
    if (f[2]) s = s + 6'd4;
    if (f[3]) s = s + 6'd4;
    if (f[4]) s = s + 6'd1;
    if (f[5]) s = s + 6'd4;
    if (f[6]) s = s + 6'd4;
    return s;
  endfunction

  function automatic logic [SkipBits-1:0] extra_skip(input logic [7:0] e);
    logic [SkipBits-1:0] s;
    s = '0;
    if (e[0]) s = s + 6'd2;
    if (e[1]) s = s + 6'd4;
    if (e[2]) s = s + 6'd4;
    if (e[3]) s = s + 6'd4;
    if (e[4]) s = s + 6'd4;
    return s;
  endfunction

  function automatic logic [SkipBits-1:0] word_skip(input logic [15:0] w,
                                                    input logic [7:0]  ver);
    logic [SkipBits-1:0] s;
    logic                v9;
    logic                v9_10;
    v9    = (ver == VerWord9);
    v9_10 = (ver == VerWord9) || (ver == VerWord10);
    s = '0;
    if (w[0]) s = s + (v9 ? 6'd2 : 6'd4);
    if (w[1]) s = s + 6'd4;
    if (w[2]) s = s + 6'd4;
    if (w[3]) s = s + 6'd4;
    if (w[4]) s = s + 6'd4;
    if (w[5]) s = s + 6'd4;
    if (!v9_10 && w[7]) s = s + 6'd4;
    if (w[13]) s = s + 6'd4;
    if (!v9_10 && w[14]) s = s + ((ver == VerWord11) ? 6'd2 : 6'd6);
    return s;
  endfunction

endpackage

/* rtl/map_cell_block_parser_unit.sv */
// Map body parser: one body byte in, at most one cell result word out.
// Output: a result is registered and appears on the master side in the cycle after its byte is taken.
// Throughput: one byte per cycle, limited only by the single output register.
// Reset: asynchronous, active low; parser returns to the flag phase, counters clear,
// version and cell count read as zero, and the output register empties.
`timescale 1ns / 1ps
module map_cell_block_parser_unit
  import mcbp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] body_byte
  input  logic        s_axis_tlast,   // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [23:0] cell_index, [24] blocked, [31:25] zero
  output logic [1:0]  m_axis_tuser,   // [0] cell_valid, [1] bad_version
  output logic        m_axis_tlast    // final_res
);

  logic [7:0]               version_q;
  logic [CellIndexBits-1:0] count_q;

  phase_e                   phase_q, phase_d;
  logic [SkipBits-1:0]      skip_q, skip_d;
  logic [7:0]               flag_q, flag_d;
  logic [31:0]              gather_q, gather_d;
  logic [3:0]               pos_q, pos_d;
  logic [CellIndexBits-1:0] done_q, done_d;
  logic                     stopped_q, stopped_d;

  logic                     out_valid_q;
  res_t                     res_q, res_d;
  logic                     res_fire;

  logic                     in_fire;
  logic                     out_free;
  logic [7:0]               b;
  logic                     eos;
  logic [CellIndexBits-1:0] done_inc;
  logic                     count_hit;
  logic                     last_cell;
  logic [31:0]              g1;
  logic [3:0]               pos_n;
  logic [SkipBits-1:0]      s6;
  logic                     cell_fin;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign eos           = s_axis_tlast;
  assign done_inc      = done_q + 1'b1;
  assign count_hit     = (done_q >= count_q);
  assign last_cell     = (done_inc >= count_q);
  assign cell_fin      = eos || last_cell;
  assign pos_n         = pos_q + 4'd1;

  always_comb begin
    g1 = gather_q;
    if (pos_q inside {[GatherStart:RecordLen - 4'd1]}) begin
      case (pos_q[1:0])
        2'd0:    g1[7:0]   = gather_q[7:0]   | b;
        2'd1:    g1[15:8]  = gather_q[15:8]  | b;
        2'd2:    g1[23:16] = gather_q[23:16] | b;
        default: g1[31:24] = gather_q[31:24] | b;
      endcase
    end
  end

  always_comb begin
    phase_d   = phase_q;
    skip_d    = skip_q;
    flag_d    = flag_q;
    gather_d  = gather_q;
    pos_d     = pos_q;
    done_d    = done_q;
    stopped_d = stopped_q;
    res_d     = '0;
    res_d.cell_index = done_q;
    res_fire  = 1'b0;
    s6        = '0;
    if (in_fire && !stopped_q) begin
      if (count_hit) begin
        res_fire        = 1'b1;
        res_d.final_res = 1'b1;
        stopped_d       = 1'b1;
      end else if (phase_q == PhFlag) begin
        if (version_q == VerRecord12) begin
          if (pos_n >= RecordLen) begin
            pos_d            = '0;
            gather_d         = '0;
            res_fire         = 1'b1;
            res_d.cell_valid = 1'b1;
            res_d.blocked    = g1[31] || (g1 <= BlockThreshold);
            res_d.final_res  = cell_fin;
            done_d           = done_inc;
            stopped_d        = cell_fin;
          end else begin
            gather_d = g1;
            pos_d    = pos_n;
            if (eos) begin
              res_fire        = 1'b1;
              res_d.final_res = 1'b1;
              stopped_d       = 1'b1;
            end
          end
        end else begin
          pos_d    = '0;
          gather_d = '0;
          res_fire = 1'b1;
          if (!(version_q inside {VerTab3, VerTab5, VerTab6, VerExtra7,
                                  [VerWord9:VerWord12]})) begin
            res_d.final_res   = 1'b1;
            res_d.bad_version = 1'b1;
            stopped_d         = 1'b1;
          end else begin
            flag_d           = b;
            res_d.cell_valid = 1'b1;
            res_d.blocked    = b[0];
            res_d.final_res  = cell_fin;
            done_d           = done_inc;
            stopped_d        = cell_fin;
            case (version_q)
              VerTab3: s6 = TabV3[b[4:0]];
              VerTab5: s6 = TabV5[b[4:0]];
              VerTab6: s6 = TabV6[b[4:0]];
              default: s6 = '0;
            endcase
            if (version_q inside {VerTab3, VerTab5, VerTab6}) begin
              skip_d  = s6;
              phase_d = (s6 != '0) ? PhSkip : PhFlag;
            end else if (version_q == VerExtra7) begin
              phase_d = PhExtra;
            end else begin
              skip_d  = flag_bit_skip(b);
              phase_d = PhWordLo;
            end
          end
        end
      end else begin
        case (phase_q)
          PhExtra: begin
            s6      = TabV7[flag_q[4:0]] + extra_skip(b);
            skip_d  = s6;
            phase_d = (s6 != '0) ? PhSkip : PhFlag;
          end
          PhWordLo: begin
            gather_d = {24'd0, b};
            phase_d  = PhWordHi;
          end
          PhWordHi: begin
            s6       = skip_q + word_skip({b, gather_q[7:0]}, version_q);
            gather_d = '0;
            skip_d   = s6;
            phase_d  = (s6 != '0) ? PhSkip : PhFlag;
          end
          default: begin
            skip_d = skip_q - 1'b1;
            if (skip_d == '0) phase_d = PhFlag;
          end
        endcase
        if (eos) begin
          res_fire        = 1'b1;
          res_d.final_res = 1'b1;
          stopped_d       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= '0;
      count_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIdxVersion: version_q <= cfg_data_i[7:0];
        CfgIdxCount:   count_q   <= cfg_data_i[CellIndexBits-1:0];
        default:       version_q <= version_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhFlag;
      skip_q    <= '0;
      flag_q    <= '0;
      gather_q  <= '0;
      pos_q     <= '0;
      done_q    <= '0;
      stopped_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      skip_q    <= skip_d;
      flag_q    <= flag_d;
      gather_q  <= gather_d;
      pos_q     <= pos_d;
      done_q    <= done_d;
      stopped_q <= stopped_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, res_q.blocked, res_q.cell_index};
  assign m_axis_tuser  = {res_q.bad_version, res_q.cell_valid};
  assign m_axis_tlast  = res_q.final_res;

  a_final_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_fire && res_d.final_res) |=> stopped_q)
    else $error("parser still running after a final word");

  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhSkip) |-> (skip_q != '0))
    else $error("skip phase with nothing left to skip");

  a_bad_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && !m_axis_tuser[0]))
    else $error("bad version word not final or carries a cell");

  a_no_result_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> !res_fire)
    else $error("result produced after parsing stopped");

endmodule
